### rtl/core/frc_pkg.sv
// Shared constants, codes and types of the fragment chain reassembler.
package frc_pkg;

  localparam int SESSIONS  = 8;
  localparam int MAX_BYTES = 64;
  localparam int SIDX_W    = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
  localparam int LEN_W     = 7;
  localparam int MEM_DEPTH = SESSIONS * MAX_BYTES;
  localparam int MADDR_W   = $clog2(MEM_DEPTH);
  localparam int QDEPTH    = 2;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic [1:0] CFG_CAPACITY = 2'd0;
  localparam logic [1:0] CFG_DEADBAND = 2'd1;
  localparam logic [1:0] CFG_GAP      = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT  = 2'd3;

  localparam logic [1:0] KIND_STATUS   = 2'd0;
  localparam logic [1:0] KIND_COMPLETE = 2'd1;
  localparam logic [1:0] KIND_SALVAGE  = 2'd2;

  localparam logic [2:0] ST_ABSORBED   = 3'd0;
  localparam logic [2:0] ST_STANDALONE = 3'd1;
  localparam logic [2:0] ST_DONE       = 3'd2;
  localparam logic [2:0] ST_ORPHAN     = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;
  localparam logic [2:0] ST_OVERFLOW   = 3'd5;

  typedef enum logic [2:0] {
    M_IDLE, M_SOLO, M_OPEN, M_MID, M_FINAL, M_ORPHAN, M_FULL, M_OVER
  } frc_mode_t;

  typedef enum logic [3:0] {
    S_IDLE, S_HEAD, S_MATCH, S_REAP, S_BYTE, S_END, S_RUN_RD, S_RUN_WR, S_EMPTY
  } frc_state_t;

  typedef struct packed {
    logic        operation;
    logic        uplink;
    logic [31:0] freq_hz;
    logic [63:0] now_us;
    logic [2:0]  frag_counter;
    logic        continues;
    logic        crc_ok;
    logic [6:0]  frag_length;
    logic [7:0]  data_byte;
    logic        frag_end;
    logic        is_solo;
    logic        is_open;
  } item_t;

  typedef struct packed {
    logic        valid;
    item_t       item;
  } qhead_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
  } qstat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [7:0]  out_byte;
    logic        out_last;
    logic [6:0]  out_length;
    logic        out_crc_bad;
    logic        out_uplink;
    logic [31:0] out_freq;
    logic [63:0] out_time;
    logic [2:0]  out_fragments;
  } result_t;

endpackage

### rtl/core/frc_if.sv
// Valid/ready channel interfaces for fragment items and result items.
interface frc_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic        uplink;
  logic [31:0] freq_hz;
  logic [63:0] now_us;
  logic [2:0]  frag_counter;
  logic        continues;
  logic        crc_ok;
  logic [6:0]  frag_length;
  logic [7:0]  data_byte;
  logic        frag_end;
  modport source (output valid, operation, uplink, freq_hz, now_us, frag_counter,
                  continues, crc_ok, frag_length, data_byte, frag_end, input ready);
  modport sink (input valid, operation, uplink, freq_hz, now_us, frag_counter,
                continues, crc_ok, frag_length, data_byte, frag_end, output ready);
endinterface

interface frc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  status;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [6:0]  out_length;
  logic        out_crc_bad;
  logic        out_uplink;
  logic [31:0] out_freq;
  logic [63:0] out_time;
  logic [2:0]  out_fragments;
  modport source (output valid, kind, status, out_byte, out_last, out_length, out_crc_bad,
                  out_uplink, out_freq, out_time, out_fragments, input ready);
  modport sink (input valid, kind, status, out_byte, out_last, out_length, out_crc_bad,
                out_uplink, out_freq, out_time, out_fragments, output ready);
endinterface

### rtl/core/fragment_chain_reassembler_core.sv
// Top level of the fragment chain reassembler: front queue and back sequencer.
//
//  channel   direction  transfer
//  in_ch     in         one fragment byte with its header, or a reap request
//  out_ch    out        one result: status, payload byte of a run, or salvage
//  cfg_*     in         register write, index 0..3, no read-back
//
// Steps: a fragment byte passes through pop, header and byte/store; a
// continuation header adds a match scan over up to SESSIONS sessions, highest
// index first, and a reap its own scan over up to SESSIONS sessions. Each byte
// of an emitted run takes a read state and then a write state, set by the
// registered read of the payload memory. Reset clears the session table and
// sequencer; payload memory is not cleared. A stalled out_ch holds the
// sequencer once it has a result to load, while the two-entry front queue keeps taking items until full.
module fragment_chain_reassembler_core
  import frc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  frc_in_if.sink      in_ch,
  frc_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  qhead_t q_head;
  qstat_t q_stat;
  logic   q_pop;

  // accept and classify into the queue
  frc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_pop  (q_pop),
    .q_head (q_head),
    .q_stat (q_stat)
  );

  // match, store and emit
  frc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_ch    (out_ch)
  );

  // queue never holds more than its depth
  a_qdepth: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= QCNT_W'(QDEPTH))
    else $error("front queue over depth");

  // status results are single, empty runs
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind == KIND_STATUS) |->
      (out_ch.out_last && out_ch.out_length == 7'd0))
    else $error("status result not a single empty run");

  // front stops taking items exactly when the queue is full
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == !q_stat.full)
    else $error("input ready disagrees with queue fill");

endmodule

### rtl/core/frc_front.sv
// Front end: accepts fragment items, tags their header class and queues them.
module frc_front
  import frc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  frc_in_if.sink in_ch,
  input  logic   q_pop,
  output qhead_t q_head,
  output qstat_t q_stat
);

  item_t             q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  item_t             in_item;
  logic              push, pop;

  always_comb begin
    in_item.operation    = in_ch.operation;
    in_item.uplink       = in_ch.uplink;
    in_item.freq_hz      = in_ch.freq_hz;
    in_item.now_us       = in_ch.now_us;
    in_item.frag_counter = in_ch.frag_counter;
    in_item.continues    = in_ch.continues;
    in_item.crc_ok       = in_ch.crc_ok;
    in_item.frag_length  = in_ch.frag_length;
    in_item.data_byte    = in_ch.data_byte;
    in_item.frag_end     = in_ch.frag_end;
    // classify the header: standalone or session opener
    in_item.is_solo      = (in_ch.frag_counter == 3'd0) && !in_ch.continues;
    in_item.is_open      = (in_ch.frag_counter == 3'd0) && in_ch.continues;
  end

  assign q_stat.full  = (count_r == QCNT_W'(QDEPTH));
  assign q_stat.count = count_r;
  assign in_ch.ready  = !q_stat.full;
  assign push         = in_ch.valid && in_ch.ready;
  assign pop          = q_pop && (count_r != '0);
  assign q_head.valid = (count_r != '0);
  assign q_head.item  = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

### rtl/core/frc_back.sv
// Back end: session table, payload store, fragment sequencer and result register.
module frc_back
  import frc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  qhead_t      q_head,
  output logic        q_pop,
  frc_out_if.source   out_ch
);

  frc_state_t state_r, state_nxt;
  item_t      item_r;
  frc_mode_t  fp_mode_r;
  logic [SIDX_W-1:0] fp_slot_r, sidx_r, run_slot_r, s_sel, free_idx;
  logic [LEN_W-1:0]  fp_count_r, fp_limit_r, run_idx_r, run_n_r;
  result_t    run_tpl_r, out_res_r, emit_res;
  logic       out_valid_r, emit, o_free;

  logic [6:0]  cap_r;
  logic [31:0] deadband_r, gap_r, timeout_r;

  logic              act_r   [SESSIONS];
  logic              up_r    [SESSIONS];
  logic [31:0]       freq_r  [SESSIONS];
  logic [2:0]        nc_r    [SESSIONS];
  logic [63:0]       time_r  [SESSIONS];
  logic              dirty_r [SESSIONS];
  logic [LEN_W-1:0]  len_r   [SESSIONS];

  logic [7:0]         mem [MEM_DEPTH];
  logic [7:0]         rd_data_r;
  logic [MADDR_W-1:0] wr_addr, rd_addr;
  logic               mem_we;

  logic [LEN_W-1:0] cap, solo_lim, open_lim, fin_n;
  logic [31:0]      fdiff;
  logic [63:0]      tdiff;
  logic             free_found, hit, over, reap_hit, take, solo_done, run_last;

  assign cap      = (cap_r > 7'(MAX_BYTES)) ? LEN_W'(MAX_BYTES) : cap_r;
  assign solo_lim = (item_r.frag_length < cap) ? item_r.frag_length : cap;
  assign open_lim = (item_r.frag_length < LEN_W'(MAX_BYTES)) ? item_r.frag_length
                                                             : LEN_W'(MAX_BYTES);
  assign o_free   = !out_valid_r || out_ch.ready;

  // one table entry is looked at a cycle
  assign s_sel = (state_r == S_BYTE || state_r == S_END) ? fp_slot_r : sidx_r;
  assign fdiff = (freq_r[s_sel] > item_r.freq_hz) ? freq_r[s_sel] - item_r.freq_hz
                                                  : item_r.freq_hz - freq_r[s_sel];
  assign tdiff = item_r.now_us - time_r[s_sel];
  assign hit   = act_r[s_sel] && (up_r[s_sel] == item_r.uplink)
              && (nc_r[s_sel] == item_r.frag_counter) && (fdiff <= deadband_r)
              && (item_r.now_us >= time_r[s_sel]) && (tdiff <= {32'd0, gap_r});
  assign over  = {1'b0, item_r.frag_length} > (8'(MAX_BYTES) - {1'b0, len_r[s_sel]});
  assign reap_hit = act_r[s_sel] && (item_r.now_us > time_r[s_sel])
                 && (tdiff > {32'd0, timeout_r});
  assign fin_n = (len_r[s_sel] > cap) ? cap : len_r[s_sel];
  assign take  = fp_count_r < fp_limit_r;
  assign solo_done = !take && ((fp_limit_r != '0) || o_free);
  assign run_last  = (run_idx_r + 1'b1) == run_n_r;

  // lowest free session
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SESSIONS - 1; i >= 0; i--) begin
      if (!act_r[i]) begin
        free_found = 1'b1;
        free_idx   = SIDX_W'(i);
      end
    end
  end

  assign wr_addr = MADDR_W'(int'(fp_slot_r) * MAX_BYTES + int'(len_r[fp_slot_r]));
  assign rd_addr = MADDR_W'(int'(run_slot_r) * MAX_BYTES + int'(run_idx_r));
  assign mem_we  = (state_r == S_BYTE) && take && (fp_mode_r != M_SOLO)
                && (len_r[fp_slot_r] < LEN_W'(MAX_BYTES));

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= item_r.data_byte;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RUN_RD) rd_data_r <= mem[rd_addr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (q_head.valid) state_nxt = S_HEAD;
      S_HEAD: begin
        if (item_r.operation) state_nxt = (fp_mode_r == M_IDLE) ? S_REAP : S_IDLE;
        else if (fp_mode_r != M_IDLE || item_r.is_solo || item_r.is_open)
          state_nxt = S_BYTE;
        else state_nxt = S_MATCH;
      end
      S_MATCH: if (hit || sidx_r == '0) state_nxt = S_BYTE;
      S_REAP: begin
        if (reap_hit) state_nxt = (len_r[s_sel] == '0) ? S_EMPTY : S_RUN_RD;
        else if (sidx_r == SIDX_W'(SESSIONS - 1)) state_nxt = S_IDLE;
      end
      S_BYTE: begin
        if (!(take && fp_mode_r == M_SOLO && !o_free))
          state_nxt = item_r.frag_end ? S_END : S_IDLE;
      end
      S_END: begin
        case (fp_mode_r)
          M_SOLO:  if (solo_done) state_nxt = S_IDLE;
          M_FINAL: state_nxt = (fin_n == '0) ? S_EMPTY : S_RUN_RD;
          default: if (o_free) state_nxt = S_IDLE;
        endcase
      end
      S_RUN_RD: state_nxt = S_RUN_WR;
      S_RUN_WR: if (o_free) state_nxt = run_last ? S_IDLE : S_RUN_RD;
      S_EMPTY:  if (o_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs: queue pop and result to load
  always_comb begin
    q_pop    = (state_r == S_IDLE) && q_head.valid;
    emit     = 1'b0;
    emit_res = '0;
    emit_res.out_last = 1'b1;
    case (state_r)
      S_BYTE: begin
        if (take && fp_mode_r == M_SOLO && o_free) begin
          emit                = 1'b1;
          emit_res.kind       = KIND_COMPLETE;
          emit_res.status     = ST_STANDALONE;
          emit_res.out_byte   = item_r.data_byte;
          emit_res.out_last   = (fp_count_r + 1'b1) == fp_limit_r;
          emit_res.out_length = fp_limit_r;
        end
      end
      S_END: begin
        case (fp_mode_r)
          M_SOLO: begin
            emit_res.kind       = KIND_COMPLETE;
            emit_res.status     = ST_STANDALONE;
            emit_res.out_last   = take ? ((fp_count_r + 1'b1) == fp_limit_r) : 1'b1;
            emit_res.out_length = fp_limit_r;
            emit = o_free && (take || fp_limit_r == '0);
          end
          M_FINAL: emit = 1'b0;
          M_ORPHAN: begin emit = o_free; emit_res.status = ST_ORPHAN;   end
          M_FULL:   begin emit = o_free; emit_res.status = ST_FULL;     end
          M_OVER:   begin emit = o_free; emit_res.status = ST_OVERFLOW; end
          default:  begin emit = o_free; emit_res.status = ST_ABSORBED; end
        endcase
      end
      S_RUN_WR: begin
        emit                = o_free;
        emit_res            = run_tpl_r;
        emit_res.out_byte   = rd_data_r;
        emit_res.out_last   = run_last;
        emit_res.out_length = run_n_r;
      end
      S_EMPTY: begin
        emit     = o_free;
        emit_res = run_tpl_r;
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) item_r <= q_head.item;
    if (emit)  out_res_r <= emit_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      fp_mode_r   <= M_IDLE;
      fp_slot_r   <= '0;
      fp_count_r  <= '0;
      fp_limit_r  <= '0;
      sidx_r      <= '0;
      run_slot_r  <= '0;
      run_idx_r   <= '0;
      run_n_r     <= '0;
      run_tpl_r   <= '0;
      cap_r       <= 7'd64;
      deadband_r  <= 32'd10000;
      gap_r       <= 32'd1000000;
      timeout_r   <= 32'd5000000;
      for (int i = 0; i < SESSIONS; i++) begin
        act_r[i]   <= 1'b0;
        up_r[i]    <= 1'b0;
        freq_r[i]  <= '0;
        nc_r[i]    <= '0;
        time_r[i]  <= '0;
        dirty_r[i] <= 1'b0;
        len_r[i]   <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          CFG_CAPACITY: cap_r      <= cfg_data[6:0];
          CFG_DEADBAND: deadband_r <= cfg_data;
          CFG_GAP:      gap_r      <= cfg_data;
          CFG_TIMEOUT:  timeout_r  <= cfg_data;
          default:      cap_r      <= cap_r;
        endcase
      end

      case (state_r)
        S_HEAD: begin
          sidx_r <= item_r.operation ? '0 : SIDX_W'(SESSIONS - 1);
          if (!item_r.operation && fp_mode_r == M_IDLE) begin
            fp_count_r <= '0;
            if (item_r.is_solo) begin
              fp_mode_r  <= M_SOLO;
              fp_limit_r <= solo_lim;
              fp_slot_r  <= '0;
            end else if (item_r.is_open && free_found) begin
              act_r[free_idx]   <= 1'b1;
              up_r[free_idx]    <= item_r.uplink;
              freq_r[free_idx]  <= item_r.freq_hz;
              nc_r[free_idx]    <= 3'd1;
              time_r[free_idx]  <= item_r.now_us;
              dirty_r[free_idx] <= 1'b0;
              len_r[free_idx]   <= '0;
              fp_mode_r         <= M_OPEN;
              fp_slot_r         <= free_idx;
              fp_limit_r        <= open_lim;
            end else begin
              // no room for an opener; a continuation waits for the scan
              fp_limit_r <= '0;
              fp_slot_r  <= '0;
              if (item_r.is_open) fp_mode_r <= M_FULL;
            end
          end
        end
        S_MATCH: begin
          if (hit) begin
            if (over) begin
              act_r[s_sel] <= 1'b0;
              fp_mode_r    <= M_OVER;
            end else begin
              fp_slot_r     <= s_sel;
              fp_limit_r    <= item_r.frag_length;
              time_r[s_sel] <= item_r.now_us;
              if (!item_r.crc_ok) dirty_r[s_sel] <= 1'b1;
              fp_mode_r <= item_r.continues ? M_MID : M_FINAL;
              if (item_r.continues) nc_r[s_sel] <= item_r.frag_counter + 3'd1;
            end
          end else if (sidx_r == '0) begin
            fp_mode_r <= M_ORPHAN;
          end else begin
            sidx_r <= sidx_r - 1'b1;
          end
        end
        S_REAP: begin
          if (reap_hit) begin
            // salvage this session, whole stored length
            act_r[s_sel] <= 1'b0;
            run_slot_r   <= s_sel;
            run_idx_r    <= '0;
            run_n_r      <= len_r[s_sel];
            run_tpl_r    <= '{kind: KIND_SALVAGE, status: ST_ABSORBED, out_byte: 8'd0,
                              out_last: 1'b1, out_length: 7'd0,
                              out_crc_bad: dirty_r[s_sel], out_uplink: up_r[s_sel],
                              out_freq: freq_r[s_sel], out_time: time_r[s_sel],
                              out_fragments: nc_r[s_sel]};
          end else if (sidx_r != SIDX_W'(SESSIONS - 1)) begin
            sidx_r <= sidx_r + 1'b1;
          end
        end
        S_BYTE: begin
          if (!(take && fp_mode_r == M_SOLO && !o_free)) begin
            if (take) fp_count_r <= fp_count_r + 1'b1;
            if (mem_we) len_r[fp_slot_r] <= len_r[fp_slot_r] + 1'b1;
          end
        end
        S_END: begin
          case (fp_mode_r)
            M_SOLO: begin
              if (take && o_free) fp_count_r <= fp_count_r + 1'b1;
              if (solo_done) begin
                fp_mode_r  <= M_IDLE;
                fp_count_r <= '0;
                fp_limit_r <= '0;
                fp_slot_r  <= '0;
              end
            end
            M_FINAL: begin
              act_r[s_sel] <= 1'b0;
              run_slot_r   <= s_sel;
              run_idx_r    <= '0;
              run_n_r      <= fin_n;
              run_tpl_r    <= '{kind: KIND_COMPLETE, status: ST_DONE, out_byte: 8'd0,
                                out_last: 1'b1, out_length: 7'd0,
                                out_crc_bad: dirty_r[s_sel], out_uplink: 1'b0,
                                out_freq: 32'd0, out_time: 64'd0, out_fragments: 3'd0};
              fp_mode_r    <= M_IDLE;
              fp_count_r   <= '0;
              fp_limit_r   <= '0;
              fp_slot_r    <= '0;
            end
            default: begin
              if (o_free) begin
                fp_mode_r  <= M_IDLE;
                fp_count_r <= '0;
                fp_limit_r <= '0;
                fp_slot_r  <= '0;
              end
            end
          endcase
        end
        S_RUN_WR: if (o_free) run_idx_r <= run_idx_r + 1'b1;
        default: sidx_r <= sidx_r;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = out_res_r.kind;
  assign out_ch.status        = out_res_r.status;
  assign out_ch.out_byte      = out_res_r.out_byte;
  assign out_ch.out_last      = out_res_r.out_last;
  assign out_ch.out_length    = out_res_r.out_length;
  assign out_ch.out_crc_bad   = out_res_r.out_crc_bad;
  assign out_ch.out_uplink    = out_res_r.out_uplink;
  assign out_ch.out_freq      = out_res_r.out_freq;
  assign out_ch.out_time      = out_res_r.out_time;
  assign out_ch.out_fragments = out_res_r.out_fragments;

endmodule
